FILE: design/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg
// Types, codes and small helpers shared by the timecode counter modules.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // Item kinds; code 3 means nothing and is ignored by the datapath.
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_QUERY = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        RATE_24      = 2'd0,
        RATE_25      = 2'd1,
        RATE_30_DROP = 2'd2,
        RATE_30      = 2'd3
    } t_rate;

    // Quarter-frame piece selector
    typedef enum logic [2:0] {
        PIECE_FRAME_LO = 3'd0,
        PIECE_FRAME_HI = 3'd1,
        PIECE_SEC_LO   = 3'd2,
        PIECE_SEC_HI   = 3'd3,
        PIECE_MIN_LO   = 3'd4,
        PIECE_MIN_HI   = 3'd5,
        PIECE_HOUR_LO  = 3'd6,
        PIECE_HOUR_HI  = 3'd7
    } t_piece;

    localparam logic [5:0] SEC_PER_MIN   = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
    localparam logic [4:0] HOUR_WRAP     = 5'd24;
    localparam logic [4:0] DROP_FIRST_FR = 5'd2;

    typedef struct packed {
        logic [4:0] frames;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        t_rate      rate;
    } t_pos;

    typedef struct packed {
        t_mode      mode;
        t_pos       load;
        logic [2:0] piece_index;
    } t_item;

    typedef struct packed {
        t_pos       pos;
        logic [3:0] piece_nibble;
        logic       status;
    } t_result;

    function automatic logic [4:0] frame_limit(input t_rate rate);
        logic [4:0] lim;
        unique case (rate)
            RATE_24: lim = 5'd24;
            RATE_25: lim = 5'd25;
            default: lim = 5'd30;
        endcase
        return lim;
    endfunction

    // True for the tens of minutes (no frames dropped there)
    function automatic logic is_tenth_minute(input logic [5:0] minutes);
        logic hit;
        unique case (minutes)
            6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50, 6'd60: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

FILE: design/mtc_step.sv
// ----------------------------------------------------------------------------
// mtc_step
// Next position and result for one item: load check, frame advance, query.
// ----------------------------------------------------------------------------
module mtc_step (
    input  mtc_pkg::t_pos    i_pos,
    input  mtc_pkg::t_item   i_item,
    output mtc_pkg::t_pos    o_pos,
    output mtc_pkg::t_result o_res
);

    logic [5:0] w_f_inc;
    logic [6:0] w_s_inc;
    logic [6:0] w_m_inc;
    logic [4:0] w_h_inc;
    logic       w_f_wrap;
    logic       w_s_wrap;
    logic       w_m_wrap;
    logic       w_load_ok;
    logic       w_load_drop;
    mtc_pkg::t_pos w_tick;
    mtc_pkg::t_pos w_ld;

    assign w_ld     = i_item.load;
    assign w_f_inc  = {1'b0, i_pos.frames} + 6'd1;
    assign w_s_inc  = {1'b0, i_pos.seconds} + 7'd1;
    assign w_m_inc  = {1'b0, i_pos.minutes} + 7'd1;
    assign w_h_inc  = i_pos.hours + 5'd1;
    assign w_f_wrap = w_f_inc >= {1'b0, mtc_pkg::frame_limit(i_pos.rate)};
    assign w_s_wrap = w_s_inc >= {1'b0, mtc_pkg::SEC_PER_MIN};
    assign w_m_wrap = w_m_inc >= {1'b0, mtc_pkg::MIN_PER_HOUR};

    // drop-frame: frames 0 and 1 do not exist at second 0 of non-tenth minutes
    assign w_load_drop = (w_ld.rate == mtc_pkg::RATE_30_DROP) && (w_ld.seconds == 6'd0)
                       && !mtc_pkg::is_tenth_minute(w_ld.minutes)
                       && (w_ld.frames < mtc_pkg::DROP_FIRST_FR);
    assign w_load_ok = (w_ld.frames < mtc_pkg::frame_limit(w_ld.rate)) && !w_load_drop
                     && (w_ld.seconds < mtc_pkg::SEC_PER_MIN)
                     && (w_ld.minutes < mtc_pkg::MIN_PER_HOUR);

    always_comb begin
        w_tick = i_pos;
        if (!w_f_wrap) begin
            w_tick.frames = w_f_inc[4:0];
        end else begin
            w_tick.seconds = w_s_wrap ? 6'd0 : w_s_inc[5:0];
            if (w_s_wrap) begin
                w_tick.minutes = w_m_wrap ? 6'd0 : w_m_inc[5:0];
                if (w_m_wrap) begin
                    w_tick.hours = (w_h_inc == mtc_pkg::HOUR_WRAP) ? 5'd0 : w_h_inc;
                end
            end
            if ((i_pos.rate == mtc_pkg::RATE_30_DROP) && (w_tick.seconds == 6'd0)
                && !mtc_pkg::is_tenth_minute(w_tick.minutes)) begin
                w_tick.frames = mtc_pkg::DROP_FIRST_FR;
            end else begin
                w_tick.frames = 5'd0;
            end
        end
    end

    always_comb begin
        o_pos              = i_pos;
        o_res.piece_nibble = 4'd0;
        o_res.status       = 1'b0;
        unique case (i_item.mode)
            mtc_pkg::MODE_LOAD: begin
                if (w_load_ok) begin
                    o_pos = w_ld;
                end else begin
                    o_res.status = 1'b1;
                end
            end
            mtc_pkg::MODE_TICK: begin
                o_pos = w_tick;
            end
            mtc_pkg::MODE_QUERY: begin
                unique case (mtc_pkg::t_piece'(i_item.piece_index))
                    mtc_pkg::PIECE_FRAME_LO: o_res.piece_nibble = i_pos.frames[3:0];
                    mtc_pkg::PIECE_FRAME_HI: o_res.piece_nibble = {3'd0, i_pos.frames[4]};
                    mtc_pkg::PIECE_SEC_LO:   o_res.piece_nibble = i_pos.seconds[3:0];
                    mtc_pkg::PIECE_SEC_HI:   o_res.piece_nibble = {2'd0, i_pos.seconds[5:4]};
                    mtc_pkg::PIECE_MIN_LO:   o_res.piece_nibble = i_pos.minutes[3:0];
                    mtc_pkg::PIECE_MIN_HI:   o_res.piece_nibble = {2'd0, i_pos.minutes[5:4]};
                    mtc_pkg::PIECE_HOUR_LO:  o_res.piece_nibble = i_pos.hours[3:0];
                    default: o_res.piece_nibble = {1'b0, i_pos.rate, i_pos.hours[4]};
                endcase
            end
            default: begin
                o_pos = i_pos;
            end
        endcase
        o_res.pos = o_pos;
    end

endmodule

FILE: design/midi_timecode_position_counter.sv
// ----------------------------------------------------------------------------
// midi_timecode_position_counter
// SMPTE / MIDI timecode position counter with load, frame advance and
// quarter-frame query.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled and returns one result per item, in
// order. Each item passes an input register, the position logic and a result
// register; throughput is one item a cycle while results are taken, set by the
// combinational carry chain of the position counter, which is updated as the
// item leaves the input register. A full result register stalls the input side
// only while the downstream holds tready low. After reset the position is
// 00:00:00:00 at 24 fps.
// Item kinds (s_axis_tuser): load checks and stores a position, or flags it
// as rejected and keeps the old one; tick advances one frame with carries
// (drop-frame skips frames 0 and 1 at second 0 of minutes that are not a
// multiple of ten; hours wrap at 24, or at 32 if loaded above 23); query
// returns one quarter-frame nibble. Kind 3 is ignored. Every result carries
// the position as it stands after the item.
// ----------------------------------------------------------------------------
module midi_timecode_position_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] load_frames, [10:5] load_seconds, [16:11] load_minutes,
    // [21:17] load_hours, [23:22] load_rate, [26:24] piece_index, rest zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] frames_now, [10:5] seconds_now, [16:11] minutes_now,
    // [21:17] hours_now, [23:22] rate_now, [27:24] piece_nibble, rest zero
    output logic [31:0] m_axis_tdata,
    // [0] status
    output logic [0:0]  m_axis_tuser
);

    mtc_pkg::t_item   r_in;
    logic             r_in_valid;
    mtc_pkg::t_pos    r_pos;
    mtc_pkg::t_result r_res;
    logic             r_out_valid;

    mtc_pkg::t_item   w_item;
    mtc_pkg::t_pos    n_pos;
    mtc_pkg::t_result n_res;
    logic             w_adv;

    // unpack the incoming item
    assign w_item.mode         = mtc_pkg::t_mode'(s_axis_tuser);
    assign w_item.load.frames  = s_axis_tdata[4:0];
    assign w_item.load.seconds = s_axis_tdata[10:5];
    assign w_item.load.minutes = s_axis_tdata[16:11];
    assign w_item.load.hours   = s_axis_tdata[21:17];
    assign w_item.load.rate    = mtc_pkg::t_rate'(s_axis_tdata[23:22]);
    assign w_item.piece_index  = s_axis_tdata[26:24];

    // result register moves when empty or being taken
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;

    mtc_step u_step (
        .i_pos  (r_pos),
        .i_item (r_in),
        .o_pos  (n_pos),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_pos <= n_pos;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= w_item;
        end
        if (w_adv && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_res.piece_nibble, r_res.pos.rate, r_res.pos.hours,
                            r_res.pos.minutes, r_res.pos.seconds, r_res.pos.frames};
    assign m_axis_tuser  = r_res.status;

    // stored position stays a legal timecode
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos.seconds < mtc_pkg::SEC_PER_MIN) && (r_pos.minutes < mtc_pkg::MIN_PER_HOUR)
        && (r_pos.frames < mtc_pkg::frame_limit(r_pos.rate)))
        else $error("position out of range");

    // dropped frames never show up in the stored position
    a_drop_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pos.rate == mtc_pkg::RATE_30_DROP) && (r_pos.seconds == 6'd0)
         && !mtc_pkg::is_tenth_minute(r_pos.minutes))
        |-> (r_pos.frames >= mtc_pkg::DROP_FIRST_FR))
        else $error("dropped frame number held");

    // a rejected load carries no nibble
    a_reject_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[27:24] == 4'd0))
        else $error("nibble on rejected load");

    // position only moves when an item leaves the input register
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && w_adv) |=> $stable(r_pos))
        else $error("position changed without an item");

endmodule
